@@ rtl/kpi_pkg.sv @@
// Shared constants and types for the keyframe pose interpolator.
package kpi_pkg;

    localparam int KEY_DEPTH_DEF   = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KEY_INDEX_W     = 10;
    localparam int TIME_W          = 32;
    localparam int KEY_COUNT_W     = 11;
    localparam int KEY_RATE_W      = 10;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_LANES       = 6;
    localparam int NUM_POS_LANES   = 3;
    localparam int LANE_W          = 3;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int PI_Q16          = 205887;
    localparam int TWO_PI_Q16      = 411775;
    localparam logic [KEY_RATE_W-1:0] KEY_RATE_RESET = KEY_RATE_W'(30);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic {
        REG_KEY_COUNT = 1'b0,
        REG_KEY_RATE  = 1'b1
    } reg_sel_t;

endpackage

@@ rtl/kpi_if.sv @@
// Channel interfaces for keyframe write/sample transactions and pose results.
interface kpi_key_if
    import kpi_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [KEY_INDEX_W-1:0]        key_index;
    logic signed [VALUE_WIDTH-1:0] key_pos_x;
    logic signed [VALUE_WIDTH-1:0] key_pos_y;
    logic signed [VALUE_WIDTH-1:0] key_pos_z;
    logic signed [VALUE_WIDTH-1:0] key_roll;
    logic signed [VALUE_WIDTH-1:0] key_pitch;
    logic signed [VALUE_WIDTH-1:0] key_yaw;
    logic [TIME_W-1:0]             sample_time;

    modport source (
        output valid, operation, key_index, key_pos_x, key_pos_y, key_pos_z,
               key_roll, key_pitch, key_yaw, sample_time,
        input  ready
    );
    modport sink (
        input  valid, operation, key_index, key_pos_x, key_pos_y, key_pos_z,
               key_roll, key_pitch, key_yaw, sample_time,
        output ready
    );
endinterface

interface kpi_pose_if
    import kpi_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] out_pos_x;
    logic signed [VALUE_WIDTH-1:0] out_pos_y;
    logic signed [VALUE_WIDTH-1:0] out_pos_z;
    logic signed [VALUE_WIDTH-1:0] out_roll;
    logic signed [VALUE_WIDTH-1:0] out_pitch;
    logic signed [VALUE_WIDTH-1:0] out_yaw;

    modport source (
        output valid, out_pos_x, out_pos_y, out_pos_z, out_roll, out_pitch, out_yaw,
        input  ready
    );
    modport sink (
        input  valid, out_pos_x, out_pos_y, out_pos_z, out_roll, out_pitch, out_yaw,
        output ready
    );
endinterface

@@ rtl/keyframe_pose_interpolator.sv @@
// Keyframe pose interpolator top level: key table, sequencer and config port.
//
// Usage: key_in carries transactions of two kinds. A write stores one keyframe
// (three positions, three angles, Q16.16) at key_index. A sample gives
// sample_time; the first sample with a nonzero key_count after reset or
// after any write latches the start time. The pose at that time comes out on
// pose_out, keys linearly interpolated, angles taking the short way around
// 2*pi. key_count of zero makes samples produce nothing.
// Registers key_count (0x0) and key_rate (0x4) sit on the APB port; write
// them while the block is idle.
// Flow: a sample takes one multiply for the frame position, then two key table
// reads on one RAM read port, then, unless it lands on a key, six lanes of a
// multiply step and an add step each on the one shared multiplier. key_in is
// ready again in the cycle that the result becomes valid, and stays low while
// a sample is at work.
// Results wait in an output register; a stalled receiver holds the sequencer
// at its last step but key_in is ready again once that result is taken.
// Reset clears the start latch, sets key_count to 0 and key_rate to 30; the
// key table holds nothing defined until written.
module keyframe_pose_interpolator
    import kpi_pkg::*;
#(
    parameter int KEY_DEPTH   = KEY_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    kpi_key_if.sink               key_in,
    kpi_pose_if.source            pose_out
);

    localparam int VW   = VALUE_WIDTH;
    localparam int AW   = $clog2(KEY_DEPTH);
    localparam int CW   = $clog2(KEY_DEPTH + 1);
    localparam int CW1  = CW + 1;
    localparam int EW   = (VW + 2 > 21) ? VW + 2 : 21;
    localparam int DW   = EW + 1;
    localparam int MA   = (DW > TIME_W + 1) ? DW : TIME_W + 1;
    localparam int MB   = FRAC_BITS + 1;
    localparam int PW   = MA + MB;
    localparam int POSW = TIME_W + KEY_RATE_W;
    localparam int SW   = DW + 2;
    localparam int RW   = NUM_LANES * VW;

    localparam logic signed [EW-1:0] PI_E     = EW'(PI_Q16);
    localparam logic signed [EW-1:0] NEG_PI_E = -EW'(PI_Q16);
    localparam logic signed [EW-1:0] TWO_PI_E = EW'(TWO_PI_Q16);
    localparam logic signed [SW-1:0] SAT_HI   = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);
    localparam logic [LANE_W-1:0]    LAST_LANE = LANE_W'(NUM_LANES - 1);
    localparam logic [LANE_W-1:0]    FIRST_ANGLE = LANE_W'(NUM_POS_LANES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_CLAMP,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [KEY_COUNT_W-1:0]   key_count_reg;
    logic [KEY_RATE_W-1:0]    key_rate_reg;
    logic [TIME_W-1:0]        start_time_reg;
    logic                     start_latched_reg;
    logic [TIME_W-1:0]        diff_reg;
    logic [AW-1:0]            idx_reg;
    logic [FRAC_BITS-1:0]     frac_reg;
    logic                     last_reg;
    logic [LANE_W-1:0]        lane_reg;
    logic [RW-1:0]            a_reg, b_reg;
    logic signed [EW-1:0]     al_reg;
    logic signed [VW-1:0]     res_reg [NUM_LANES];
    logic signed [VW-1:0]     out_reg [NUM_LANES];
    logic                     out_valid_reg;

    logic                     in_acc, cfg_wr, key_we, take_out;
    logic [CW-1:0]            count_eff;
    logic [TIME_W-1:0]        start_eff, diff_val;
    logic [POSW-1:0]          pos, cnt_shift, pos_c;
    logic [AW-1:0]            idx_next, raddr;
    logic                     last_next;
    logic [RW-1:0]            rdata, wdata;
    logic signed [EW-1:0]     a_ext, b_ext, a_cor, b_cor, d_ab;
    logic signed [DW-1:0]     dlt;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     prod_reg, prod_sh;
    logic signed [SW-1:0]     sum, sat_val;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (reg_sel_t'(paddr[2]))
            REG_KEY_COUNT: prdata = APB_DATA_W'(key_count_reg);
            REG_KEY_RATE:  prdata = APB_DATA_W'(key_rate_reg);
            default:       prdata = '0;
        endcase
    end

    assign key_in.ready = (state_reg == ST_IDLE);
    assign in_acc       = key_in.valid & key_in.ready;
    assign key_we       = in_acc && (op_t'(key_in.operation) == OP_WRITE)
                          && (32'(key_in.key_index) < 32'(KEY_DEPTH));
    assign wdata        = {key_in.key_yaw, key_in.key_pitch, key_in.key_roll,
                           key_in.key_pos_z, key_in.key_pos_y, key_in.key_pos_x};

    assign count_eff = (32'(key_count_reg) > 32'(KEY_DEPTH)) ? CW'(KEY_DEPTH)
                                                               : CW'(key_count_reg);
    assign start_eff = start_latched_reg ? start_time_reg : key_in.sample_time;
    assign diff_val  = (key_in.sample_time < start_eff) ? '0
                                                        : key_in.sample_time - start_eff;

    assign pos       = prod_reg[POSW-1:0];
    assign cnt_shift = POSW'(count_eff) << FRAC_BITS;
    assign pos_c     = (pos >= cnt_shift) ? (POSW'(count_eff - CW'(1)) << FRAC_BITS) : pos;
    assign idx_next  = pos_c[FRAC_BITS +: AW];
    assign last_next = (CW1'(idx_next) + CW1'(1)) == CW1'(count_eff);
    assign raddr     = (state_reg == ST_RD0) ? idx_reg + AW'(1) : idx_next;

    always_comb
    begin
        a_ext = EW'($signed(a_reg[lane_reg*VW +: VW]));
        b_ext = EW'($signed(b_reg[lane_reg*VW +: VW]));
        d_ab  = a_ext - b_ext;
        a_cor = a_ext;
        b_cor = b_ext;
        if (lane_reg >= FIRST_ANGLE)
        begin
            priority if (d_ab > PI_E)
            begin
                b_cor = b_ext + TWO_PI_E;
            end
            else if (d_ab < NEG_PI_E)
            begin
                a_cor = a_ext + TWO_PI_E;
            end
        end
        dlt = DW'(b_cor) - DW'(a_cor);
    end

    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            mul_a = MA'(dlt);
            mul_b = MB'($signed({1'b0, frac_reg}));
        end
        else
        begin
            mul_a = MA'($signed({1'b0, diff_reg}));
            mul_b = MB'($signed({1'b0, key_rate_reg}));
        end
    end

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign sum     = SW'(al_reg) + SW'(prod_sh);
    assign sat_val = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);

    assign take_out = !out_valid_reg || pose_out.ready;

    kpi_ram #(.WIDTH(RW), .DEPTH(KEY_DEPTH)) u_table (
        .clk   (clk),
        .we    (key_we),
        .waddr (AW'(key_in.key_index)),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    kpi_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op_t'(key_in.operation) == OP_SAMPLE)
                    && (count_eff != '0))
                begin
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ((frac_reg == '0) || last_reg) ? ST_OUT : ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = (lane_reg == LAST_LANE) ? ST_OUT : ST_MUL;
            ST_OUT:   state_next = take_out ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            key_count_reg     <= '0;
            key_rate_reg      <= KEY_RATE_RESET;
            start_time_reg    <= '0;
            start_latched_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            lane_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (reg_sel_t'(paddr[2]))
                    REG_KEY_COUNT: key_count_reg <= pwdata[KEY_COUNT_W-1:0];
                    REG_KEY_RATE:  key_rate_reg  <= pwdata[KEY_RATE_W-1:0];
                    default:       key_count_reg <= key_count_reg;
                endcase
            end
            if ((state_reg == ST_OUT) && take_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (op_t'(key_in.operation) == OP_WRITE)
                        begin
                            start_latched_reg <= 1'b0;
                        end
                        else if (count_eff != '0)
                        begin
                            start_time_reg    <= start_eff;
                            start_latched_reg <= 1'b1;
                            diff_reg          <= diff_val;
                        end
                    end
                end
                ST_CLAMP:
                begin
                    idx_reg  <= idx_next;
                    frac_reg <= pos_c[FRAC_BITS-1:0];
                    last_reg <= last_next;
                end
                ST_RD0:
                begin
                    a_reg <= rdata;
                end
                ST_RD1:
                begin
                    b_reg    <= rdata;
                    lane_reg <= '0;
                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        res_reg[i] <= a_reg[i*VW +: VW];
                    end
                end
                ST_MUL:
                begin
                    al_reg <= a_cor;
                end
                ST_ADD:
                begin
                    res_reg[lane_reg] <= sat_val[VW-1:0];
                    lane_reg          <= lane_reg + LANE_W'(1);
                end
                ST_OUT:
                begin
                    if (take_out)
                    begin
                        out_reg <= res_reg;
                    end
                end
                default:
                begin
                    lane_reg <= lane_reg;
                end
            endcase
        end
    end

    assign pose_out.valid     = out_valid_reg;
    assign pose_out.out_pos_x = out_reg[0];
    assign pose_out.out_pos_y = out_reg[1];
    assign pose_out.out_pos_z = out_reg[2];
    assign pose_out.out_roll  = out_reg[3];
    assign pose_out.out_pitch = out_reg[4];
    assign pose_out.out_yaw   = out_reg[5];

    a_zero_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && key_in.operation && (count_eff == '0)) |=> (state_reg == ST_IDLE))
        else $error("sample with zero key count started work");

    a_write_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !key_in.operation) |=> !start_latched_reg)
        else $error("key write left start time latched");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD0) |-> (CW1'(idx_reg) < CW1'(count_eff)))
        else $error("frame index beyond key count");

    a_lane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_ADD) |-> (lane_reg <= LAST_LANE))
        else $error("lane counter out of range");

endmodule

@@ rtl/kpi_ram.sv @@
// Generic simple dual-port RAM with registered read.
module kpi_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/kpi_mul.sv @@
// Shared signed multiplier with registered product.
module kpi_mul
#(
    parameter int A_W = 35,
    parameter int B_W = 17
)
(
    input  logic                      clk,
    input  logic signed [A_W-1:0]     a,
    input  logic signed [B_W-1:0]     b,
    output logic signed [A_W+B_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

@@ tb/kpi_pose_checker.sv @@
// Pose checker: watches key and pose channels, predicts poses and compares them.
`timescale 1ns / 100ps
module kpi_pose_checker
    import kpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    kpi_key_if                    key_in,
    kpi_pose_if                   pose_out,
    output int                    fail_count,
    output int                    poses_pending
);
    typedef struct packed {
        logic signed [31:0] px, py, pz, roll, pitch, yaw;
    } pose_t;

    pose_t       key_table [KEY_DEPTH_DEF];
    pose_t       pose_queue [$];
    logic [31:0] start_time;
    logic        start_latched;
    logic [10:0] key_count;
    logic [9:0]  key_rate;

    assign poses_pending = pose_queue.size();

    function automatic longint floor16(longint v);
        longint r;
        r = v >>> 16;
        return r;
    endfunction

    function automatic logic signed [31:0] blend(longint a, longint b, int frac);
        longint d, hi, lo, s;
        d = b - a;
        hi = floor16(d);
        lo = d - hi * 65536;
        s = a + hi * frac + ((lo * frac) >>> 16);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] blend_angle(longint a, longint b, int frac);
        longint d;
        d = a - b;
        if (d > PI_Q16) b = b + TWO_PI_Q16;
        else if (d < -PI_Q16) a = a + TWO_PI_Q16;
        return blend(a, b, frac);
    endfunction

    function automatic pose_t predict_pose(logic [31:0] t);
        longint unsigned frame_pos;
        int    count, idx, frac;
        pose_t a, b, r;
        count = key_count > KEY_DEPTH_DEF ? KEY_DEPTH_DEF : key_count;
        if (t < start_time) frame_pos = 0;
        else frame_pos = longint'(t - start_time) * key_rate;
        if (frame_pos >= (longint'(count) << 16)) frame_pos = longint'(count - 1) << 16;
        idx = int'(frame_pos >> 16);
        frac = int'(frame_pos & 64'hFFFF);
        a = key_table[idx];
        if (frac == 0 || idx + 1 == count) return a;
        b = key_table[idx + 1];
        r.px = blend(a.px, b.px, frac);
        r.py = blend(a.py, b.py, frac);
        r.pz = blend(a.pz, b.pz, frac);
        r.roll = blend_angle(a.roll, b.roll, frac);
        r.pitch = blend_angle(a.pitch, b.pitch, frac);
        r.yaw = blend_angle(a.yaw, b.yaw, frac);
        return r;
    endfunction

    task automatic compare_lane(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            start_time <= '0;
            start_latched <= 1'b0;
            key_count <= '0;
            key_rate <= KEY_RATE_RESET;
            pose_queue.delete();
        end
        else
        begin
            pose_t exp_p;
            if (psel && penable && pwrite)
            begin
                if (reg_sel_t'(paddr[2]) == REG_KEY_COUNT) key_count <= pwdata[10:0];
                else key_rate <= pwdata[9:0];
            end
            if (key_in.valid && key_in.ready)
            begin
                if (op_t'(key_in.operation) == OP_WRITE)
                begin
                    key_table[key_in.key_index] = {key_in.key_pos_x, key_in.key_pos_y,
                        key_in.key_pos_z, key_in.key_roll, key_in.key_pitch, key_in.key_yaw};
                    start_latched = 1'b0;
                end
                else if (key_count != 0)
                begin
                    if (!start_latched)
                    begin
                        start_time = key_in.sample_time;
                        start_latched = 1'b1;
                    end
                    pose_queue.push_back(predict_pose(key_in.sample_time));
                end
            end
            if (pose_out.valid && pose_out.ready)
            begin
                if (pose_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected pose expected none actual %h", $time,
                        pose_out.out_pos_x);
                end
                else
                begin
                    exp_p = pose_queue.pop_front();
                    compare_lane("pos_x", exp_p.px, pose_out.out_pos_x);
                    compare_lane("pos_y", exp_p.py, pose_out.out_pos_y);
                    compare_lane("pos_z", exp_p.pz, pose_out.out_pos_z);
                    compare_lane("roll", exp_p.roll, pose_out.out_roll);
                    compare_lane("pitch", exp_p.pitch, pose_out.out_pitch);
                    compare_lane("yaw", exp_p.yaw, pose_out.out_yaw);
                end
            end
        end
    end
endmodule

@@ tb/keyframe_pose_interpolator_tb.sv @@
// Testbench top: drives key transactions and register writes, gives the verdict.
`timescale 1ns / 100ps
module keyframe_pose_interpolator_tb;
    import kpi_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    poses_pending;
    int                    send_idle = 0;
    int                    recv_idle = 0;
    int                    hold_cycles = 0;
    int                    written_limit = 0;
    int                    active_count = 0;

    kpi_key_if  key_ch ();
    kpi_pose_if pose_ch ();

    keyframe_pose_interpolator u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .key_in(key_ch), .pose_out(pose_ch)
    );

    kpi_pose_checker u_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .key_in(key_ch), .pose_out(pose_ch),
        .fail_count(fail_count), .poses_pending(poses_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        key_ch.valid = 1'b0;
        key_ch.operation = OP_WRITE;
        key_ch.key_index = '0;
        key_ch.key_pos_x = '0;
        key_ch.key_pos_y = '0;
        key_ch.key_pos_z = '0;
        key_ch.key_roll = '0;
        key_ch.key_pitch = '0;
        key_ch.key_yaw = '0;
        key_ch.sample_time = '0;
        pose_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pose_ch.ready <= 1'b0;
        end
        else
            pose_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(reg_sel_t sel, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_key(op_t op, logic [9:0] index, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [31:0] roll, logic [31:0] pitch,
                            logic [31:0] yaw, logic [31:0] t);
        @(posedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.operation <= op;
        key_ch.key_index <= index;
        key_ch.key_pos_x <= px;
        key_ch.key_pos_y <= py;
        key_ch.key_pos_z <= pz;
        key_ch.key_roll <= roll;
        key_ch.key_pitch <= pitch;
        key_ch.key_yaw <= yaw;
        key_ch.sample_time <= t;
        @(negedge clk);
        while (!key_ch.ready) @(negedge clk);
        @(posedge clk);
        key_ch.valid <= 1'b0;
    endtask

    task automatic write_random_key(logic [9:0] index);
        send_key(OP_WRITE, index, $urandom, $urandom, $urandom,
                 $urandom_range(1 << 20) - (1 << 19), $urandom, $urandom_range(500000), 0);
        if (index >= written_limit) written_limit = index + 1;
    endtask

    task automatic send_sample(logic [31:0] t);
        send_key(OP_SAMPLE, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, t);
    endtask

    task automatic drain();
        while (poses_pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_mode(logic [10:0] count, logic [9:0] rate);
        drain();
        write_reg(REG_KEY_COUNT, 32'(count));
        write_reg(REG_KEY_RATE, 32'(rate));
        active_count = int'(count);
    endtask

    initial
    begin
        int phase, n, base, span;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        send_sample(32'h1234);
        send_key(OP_WRITE, 0, 32'h7FFFFFFF, 32'h80000000, 0, PI_Q16, -PI_Q16, 0, 0);
        send_key(OP_WRITE, 1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, -PI_Q16,
                 PI_Q16, 32'h7FFFFFFF, 0);
        send_key(OP_WRITE, 2, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 10, 0);
        send_key(OP_WRITE, 1023, 32'hFFFFFFFF, 1, 2, 3, 4, 5, 0);
        written_limit = 3;
        for (n = 3; n < 24; n++) write_random_key(10'(n));
        set_mode(3, 1023);
        send_sample(32'h00010000);
        send_sample(32'h00010001);
        send_sample(32'h00010020);
        send_sample(32'h00000000);
        send_sample(32'hFFFFFFFF);
        set_mode(2, 1);
        send_sample(0);
        send_sample(32'h8000);
        send_sample(32'h10000);
        send_sample(32'h20000);
        set_mode(1024, 1);
        send_sample(5);
        send_sample(32'hFFFFFFFF);
        set_mode(11'h7FF, 1023);
        send_sample(100);
        send_sample(32'hFFFF0000);
        set_mode(0, 30);
        send_sample(32'h5555);
        send_sample(32'hAAAA);
        set_mode(1024, 30);
        for (phase = 0; phase < 3; phase++)
        begin
            drain();
            send_idle = (phase == 0) ? 36 : (phase == 1) ? 69 : 0;
            recv_idle = (phase == 0) ? 69 : (phase == 1) ? 36 : 0;
            set_mode(11'($urandom_range(2, 20)), 10'($urandom_range(1, 1023)));
            if (phase == 2) hold_cycles = 400;
            for (n = 0; n < 130; n++)
            begin
                if ($urandom_range(9) == 0)
                    write_random_key(10'($urandom_range(active_count - 1)));
                else
                begin
                    base = $urandom;
                    span = $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 18);
                    send_sample(base[0] ? base : span);
                end
            end
        end
        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/kpi_pkg.sv
rtl/kpi_if.sv
rtl/kpi_ram.sv
rtl/kpi_mul.sv
rtl/keyframe_pose_interpolator.sv
tb/kpi_pose_checker.sv
tb/keyframe_pose_interpolator_tb.sv
